@@ rtl/core/csin_pkg.sv @@
// shared constants, types and the arctan table of the cordic sine pipeline
`default_nettype none

package csin_pkg;

  localparam int FRACTION_BITS = 11;
  localparam int ITERATIONS    = 11;
  localparam int ANGLE_WIDTH   = 32;
  localparam int SINE_WIDTH    = 13;

  // constants scaled by 2^FRACTION_BITS, from nine-decimal values
  localparam longint unsigned TWO_PI_Q =
    ((64'd6283185307 << FRACTION_BITS) + 64'd500000000) / 64'd1000000000;
  localparam longint unsigned PI_HALF_Q =
    ((64'd1570796327 << FRACTION_BITS) + 64'd500000000) / 64'd1000000000;
  localparam longint unsigned TWO_DIV_PI_Q =
    ((64'd636619772 << FRACTION_BITS) + 64'd500000000) / 64'd1000000000;
  localparam longint unsigned GAIN_Q =
    (64'd607252935 << FRACTION_BITS) / 64'd1000000000;

  // remainder width, quotient bits of the modulo chain, quadrant product width
  localparam int R_W       = $clog2(TWO_PI_Q);
  localparam int MOD_STEPS = $clog2(((64'd1 << (ANGLE_WIDTH - 1)) / TWO_PI_Q) + 64'd1);
  localparam int PROD_W    = R_W + $clog2(TWO_DIV_PI_Q + 64'd1);
  localparam int K_W       = PROD_W - 2 * FRACTION_BITS;

  // cordic datapath widths
  localparam int XY_W = FRACTION_BITS + 4;
  localparam int P_W  = FRACTION_BITS + 4;
  localparam int SH_W = $clog2(ITERATIONS);

  localparam int SINE_MAX = (1 << (SINE_WIDTH - 1)) - 1;
  localparam int SINE_MIN = -(1 << (SINE_WIDTH - 1));

  typedef struct packed {
    logic                   neg;
    logic [ANGLE_WIDTH-1:0] rem;
  } csin_mod_t;

  typedef struct packed {
    logic                  flip;
    logic signed [XY_W-1:0] x;
    logic signed [XY_W-1:0] y;
    logic signed [P_W-1:0]  p;
  } csin_rot_t;

  // arctan(2^-i) scaled by 2^FRACTION_BITS, truncated
  function automatic logic [P_W-1:0] csin_atan(input int idx);
    longint unsigned pico;
    longint unsigned q;
    unique case (idx % 16)
      0:       pico = 64'd785398163397;
      1:       pico = 64'd463647609001;
      2:       pico = 64'd244978663127;
      3:       pico = 64'd124354994547;
      4:       pico = 64'd62418809996;
      5:       pico = 64'd31239833430;
      6:       pico = 64'd15623728620;
      7:       pico = 64'd7812341060;
      8:       pico = 64'd3906230132;
      9:       pico = 64'd1953122516;
      10:      pico = 64'd976562190;
      11:      pico = 64'd488281211;
      12:      pico = 64'd244140620;
      13:      pico = 64'd122070312;
      14:      pico = 64'd61035156;
      default: pico = 64'd30517578;
    endcase
    q = (pico << FRACTION_BITS) / 64'd1000000000000;
    return q[P_W-1:0];
  endfunction

endpackage

`default_nettype wire

@@ rtl/core/csin_mod_cell.sv @@
// one restoring step of the modulo 2*pi reduction chain
`default_nettype none

module csin_mod_cell
  import csin_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   in_vld,
  input  wire csin_mod_t              in_data,
  input  wire logic [ANGLE_WIDTH-1:0] sub,
  output logic                        out_vld,
  output csin_mod_t                   out_data
);

  logic      vld_r;
  csin_mod_t data_r;
  csin_mod_t data_nxt;

  always_comb begin
    data_nxt = in_data;
    if (in_data.rem >= sub) begin
      data_nxt.rem = in_data.rem - sub;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign out_vld  = vld_r;
  assign out_data = data_r;

endmodule

`default_nettype wire

@@ rtl/core/csin_rot_cell.sv @@
// one rotation-mode cordic iteration
`default_nettype none

module csin_rot_cell
  import csin_pkg::*;
(
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            in_vld,
  input  wire csin_rot_t       in_data,
  input  wire logic [SH_W-1:0] shift,
  input  wire logic [P_W-1:0]  atan,
  output logic                 out_vld,
  output csin_rot_t            out_data
);

  logic                   vld_r;
  csin_rot_t              data_r;
  csin_rot_t              data_nxt;
  logic signed [XY_W-1:0] xs;
  logic signed [XY_W-1:0] ys;

  assign xs = in_data.x >>> shift;
  assign ys = in_data.y >>> shift;

  always_comb begin
    data_nxt = in_data;
    if (in_data.p < 0) begin
      data_nxt.p = in_data.p + $signed(atan);
      data_nxt.x = in_data.x + ys;
      data_nxt.y = in_data.y - xs;
    end else begin
      data_nxt.p = in_data.p - $signed(atan);
      data_nxt.x = in_data.x - ys;
      data_nxt.y = in_data.y + xs;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign out_vld  = vld_r;
  assign out_data = data_r;

endmodule

`default_nettype wire

@@ rtl/core/cordic_sine_fixed_point.sv @@
// top level: pipelined fixed-point cordic sine
// Usage:
//   An angle is transferred at a rising edge where start is high and busy is
//   low. busy is tied low: the pipeline takes a new angle in every cycle, so
//   the throughput is one angle per clock.
//   in_angle is signed radians with FRACTION_BITS fraction bits; out_sine is
//   the signed sine in the same scaling, saturated to SINE_WIDTH bits.
//   out_valid is high for one cycle with out_sine; that cycle's closing edge
//   transfers the result. The receiver cannot stall, so results never wait.
//   Between the transfer and the strobe an angle passes the input register,
//   one modulo-2*pi restoring cell per quotient bit (MOD_STEPS = 18), two
//   quadrant fold stages, one cordic cell per iteration and the output
//   register. Results leave in transfer order.
//   Reset (rst_n low, synchronous) clears every valid bit in the chain;
//   angles in flight are dropped and no strobe follows. There is no
//   configuration and no state kept between angles.
`default_nettype none

module cordic_sine_fixed_point
  import csin_pkg::*;
(
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          start,
  output logic                               busy,
  input  wire logic signed [ANGLE_WIDTH-1:0] in_angle,
  output logic                               out_valid,
  output logic signed [SINE_WIDTH-1:0]       out_sine
);

  localparam logic [PROD_W-1:0]   TDP   = PROD_W'(TWO_DIV_PI_Q);
  localparam logic signed [P_W-1:0] PHQ = P_W'(PI_HALF_Q);
  localparam logic signed [P_W-1:0] PHQ2 = P_W'(2 * PI_HALF_Q);
  localparam logic signed [P_W-1:0] PHQ3 = P_W'(3 * PI_HALF_Q);
  localparam logic signed [XY_W-1:0] GAIN = XY_W'(GAIN_Q);

  logic accept;

  assign busy   = 1'b0;
  assign accept = start && !busy;

  // input register: sign and magnitude
  logic      in_vld_r;
  csin_mod_t in_data_r;
  csin_mod_t in_data_nxt;

  always_comb begin
    in_data_nxt.neg = in_angle[ANGLE_WIDTH-1];
    // most negative angle wraps to 2^(ANGLE_WIDTH-1), read as unsigned
    in_data_nxt.rem = in_data_nxt.neg ? (~in_angle + 1'b1) : in_angle;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else begin
      in_vld_r <= accept;
    end
  end

  always_ff @(posedge clk) begin
    in_data_r <= in_data_nxt;
  end

  // modulo 2*pi chain, one quotient bit per cell, msb first
  logic      mod_vld  [0:MOD_STEPS];
  csin_mod_t mod_data [0:MOD_STEPS];

  assign mod_vld[0]  = in_vld_r;
  assign mod_data[0] = in_data_r;

  for (genvar j = 0; j < MOD_STEPS; j++) begin : g_mod
    csin_mod_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .in_vld   (mod_vld[j]),
      .in_data  (mod_data[j]),
      .sub      (ANGLE_WIDTH'(TWO_PI_Q << (MOD_STEPS - 1 - j))),
      .out_vld  (mod_vld[j+1]),
      .out_data (mod_data[j+1])
    );
  end

  // quadrant stage a: r * 2/pi
  logic              qa_vld_r;
  logic              qa_neg_r;
  logic [R_W-1:0]    qa_rem_r;
  logic [PROD_W-1:0] qa_prod_r;
  logic [R_W-1:0]    rem_small;
  logic [PROD_W-1:0] rem_ext;

  assign rem_small = mod_data[MOD_STEPS].rem[R_W-1:0];
  assign rem_ext   = PROD_W'(rem_small);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      qa_vld_r <= 1'b0;
    end else begin
      qa_vld_r <= mod_vld[MOD_STEPS];
    end
  end

  always_ff @(posedge clk) begin
    qa_neg_r  <= mod_data[MOD_STEPS].neg;
    qa_rem_r  <= rem_small;
    qa_prod_r <= rem_ext * TDP;
  end

  // quadrant stage b: clamp quadrant, fold angle into the first quadrant
  logic [K_W-1:0]        k_raw;
  logic [1:0]            k;
  logic signed [P_W-1:0] k_off;
  logic signed [P_W-1:0] rem_s;
  logic signed [P_W-1:0] dif;
  logic signed [P_W-1:0] alpha;
  logic                  qb_vld_r;
  csin_rot_t             qb_data_r;
  csin_rot_t             qb_data_nxt;

  assign k_raw = qa_prod_r[PROD_W-1:2*FRACTION_BITS];
  // a rounding overflow into quadrant four counts as quadrant three
  assign k     = (k_raw > K_W'(3)) ? 2'd3 : k_raw[1:0];
  assign rem_s = $signed(P_W'(qa_rem_r));

  always_comb begin
    unique case (k)
      2'd0:    k_off = '0;
      2'd1:    k_off = PHQ;
      2'd2:    k_off = PHQ2;
      default: k_off = PHQ3;
    endcase
  end

  assign dif   = rem_s - k_off;
  assign alpha = k[0] ? (PHQ - dif) : dif;

  always_comb begin
    qb_data_nxt.flip = k[1] ^ qa_neg_r;
    qb_data_nxt.x    = GAIN;
    qb_data_nxt.y    = '0;
    qb_data_nxt.p    = alpha;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      qb_vld_r <= 1'b0;
    end else begin
      qb_vld_r <= qa_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    qb_data_r <= qb_data_nxt;
  end

  // cordic chain
  logic      rot_vld  [0:ITERATIONS];
  csin_rot_t rot_data [0:ITERATIONS];

  assign rot_vld[0]  = qb_vld_r;
  assign rot_data[0] = qb_data_r;

  for (genvar i = 0; i < ITERATIONS; i++) begin : g_rot
    csin_rot_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .in_vld   (rot_vld[i]),
      .in_data  (rot_data[i]),
      .shift    (SH_W'(i)),
      .atan     (csin_atan(i)),
      .out_vld  (rot_vld[i+1]),
      .out_data (rot_data[i+1])
    );
  end

  // sign and saturation
  logic signed [XY_W:0]         y_ext;
  logic signed [XY_W:0]         s_val;
  logic signed [SINE_WIDTH-1:0] sine_nxt;
  logic                         out_vld_r;
  logic signed [SINE_WIDTH-1:0] out_sine_r;

  assign y_ext = (XY_W + 1)'(rot_data[ITERATIONS].y);
  assign s_val = rot_data[ITERATIONS].flip ? -y_ext : y_ext;

  always_comb begin
    priority if (s_val < (XY_W + 1)'(SINE_MIN)) begin
      sine_nxt = SINE_WIDTH'(SINE_MIN);
    end else if (s_val > (XY_W + 1)'(SINE_MAX)) begin
      sine_nxt = SINE_WIDTH'(SINE_MAX);
    end else begin
      sine_nxt = s_val[SINE_WIDTH-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else begin
      out_vld_r <= rot_vld[ITERATIONS];
    end
  end

  always_ff @(posedge clk) begin
    out_sine_r <= sine_nxt;
  end

  assign out_valid = out_vld_r;
  assign out_sine  = out_sine_r;

endmodule

`default_nettype wire
